FILE: hdl/bess_pkg.sv
package bess_pkg;

   localparam int POS_W       = 27;
   localparam int ID_W        = 10;
   localparam int SINE_W      = 16;
   localparam int SINE_FRAC   = 15;
   localparam int DIFF_W      = POS_W + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int ROOT_W      = PROD_W + 1;
   localparam int DEN_W       = PROD_W - 1;
   localparam int SQRT_STEPS  = PROD_W / 2;
   localparam int MUL_STEPS   = 10;
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] REG_STATION_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STATION_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STATION_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SINE  = 3'd3;

   localparam logic signed [POS_W-1:0]  RST_STATION_X = 27'sd6371000;
   localparam logic signed [SINE_W-1:0] RST_MIN_SINE  = 16'sd5690;
   localparam logic signed [SINE_W-1:0] SINE_POS_MAX  = 16'sh7FFF;
   localparam logic signed [SINE_W-1:0] SINE_NEG_MAX  = 16'sh8000;

   typedef struct packed {
      logic signed [POS_W-1:0]  station_x;
      logic signed [POS_W-1:0]  station_y;
      logic signed [POS_W-1:0]  station_z;
      logic signed [SINE_W-1:0] min_sine_elev;
   } cfg_type;

   typedef struct packed {
      logic signed [POS_W-1:0] sat_x;
      logic signed [POS_W-1:0] sat_y;
      logic signed [POS_W-1:0] sat_z;
      logic [ID_W-1:0]         sat_id;
      logic                    last_sat;
   } sat_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SQRT,
      ST_DEN,
      ST_CHK,
      ST_DIV,
      ST_SEL
   } back_state_type;

endpackage

FILE: hdl/bess_csr.sv
module bess_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bess_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bess_pkg::POS_W-1:0]         csr_data,
   output bess_pkg::cfg_type                  cfg
);

   bess_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.station_x     <= bess_pkg::RST_STATION_X;
         cfg_ff.station_y     <= '0;
         cfg_ff.station_z     <= '0;
         cfg_ff.min_sine_elev <= bess_pkg::RST_MIN_SINE;
      end else if (csr_valid) begin
         unique case (csr_index)
            bess_pkg::REG_STATION_X: cfg_ff.station_x <= csr_data;
            bess_pkg::REG_STATION_Y: cfg_ff.station_y <= csr_data;
            bess_pkg::REG_STATION_Z: cfg_ff.station_z <= csr_data;
            bess_pkg::REG_MIN_SINE:
               cfg_ff.min_sine_elev <= csr_data[bess_pkg::SINE_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

FILE: hdl/bess_front.sv
module bess_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bess_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   output logic                                item_valid,
   input  logic                                item_ready,
   output bess_pkg::sat_item_type              item
);

   localparam int X_LO  = 0;
   localparam int Y_LO  = bess_pkg::POS_W;
   localparam int Z_LO  = 2 * bess_pkg::POS_W;
   localparam int ID_LO = 3 * bess_pkg::POS_W;

   bess_pkg::sat_item_type          mem_ff [bess_pkg::QUEUE_DEPTH];
   bess_pkg::sat_item_type          beat;
   logic [bess_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [bess_pkg::QPTR_W:0]       count_ff;
   logic                            push, pop;

   always_comb begin
      beat.sat_x    = req_tdata[X_LO +: bess_pkg::POS_W];
      beat.sat_y    = req_tdata[Y_LO +: bess_pkg::POS_W];
      beat.sat_z    = req_tdata[Z_LO +: bess_pkg::POS_W];
      beat.sat_id   = req_tdata[ID_LO +: bess_pkg::ID_W];
      beat.last_sat = req_tlast;
   end

   assign req_tready = (count_ff != (bess_pkg::QPTR_W+1)'(bess_pkg::QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = mem_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

FILE: hdl/bess_back.sv
module bess_back (
   input  logic                               clock,
   input  logic                               reset,
   input  bess_pkg::cfg_type                  cfg,
   input  logic                               item_valid,
   output logic                               item_ready,
   input  bess_pkg::sat_item_type             item,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic                               rsp_found,
   output logic [bess_pkg::ID_W-1:0]          rsp_best_id,
   output logic signed [bess_pkg::SINE_W-1:0] rsp_best_sine
);

   localparam int DW = bess_pkg::DIFF_W;
   localparam int PW = bess_pkg::PROD_W;
   localparam int RW = bess_pkg::ROOT_W;
   localparam int NW = bess_pkg::DEN_W;
   localparam int SW = bess_pkg::SINE_W;

   typedef struct packed {
      logic [RW-1:0] x;
      logic [RW-1:0] r;
   } root_type;

   function automatic root_type root_step(input logic [RW-1:0] x, input logic [RW-1:0] r,
                                          input logic [RW-1:0] b);
      root_type      res;
      logic [RW-1:0] t;
      t = r + b;
      if (x >= t) begin
         res.x = x - t;
         res.r = (r >> 1) + b;
      end else begin
         res.x = x;
         res.r = r >> 1;
      end
      return res;
   endfunction

   bess_pkg::back_state_type state_ff, state_in;

   logic signed [DW-1:0] vx_ff, vy_ff, vz_ff, gx_ff, gy_ff, gz_ff;
   logic [bess_pkg::ID_W-1:0] id_ff;
   logic                      last_ff;
   logic [3:0]                step_ff;
   logic signed [PW-1:0]      prod_ff, prod;
   logic signed [DW-1:0]      op_a, op_b;
   logic [3:0]                prev_step;
   logic [PW-1:0]             acc_v_ff, acc_u_ff;
   logic signed [PW-1:0]      dot_ff;
   logic [RW-1:0]             x_v_ff, r_v_ff, x_u_ff, r_u_ff, bit_ff;
   logic [4:0]                iter_ff;
   root_type                  step_v, step_u;
   logic [NW-1:0]             den_ff, mag_ff;
   logic [PW-1:0]             rem_ff, rem2;
   logic [SW-1:0]             q_ff;
   logic                      zero_den_ff, neg_ff;
   logic                      have_ff, have_in;
   logic signed [SW-1:0]      best_sine_ff, best_sine_in, sine;
   logic [bess_pkg::ID_W-1:0] best_id_ff, best_id_in;
   logic                      qualify, out_free, commit, emit;
   logic                      rsp_valid_ff, rsp_found_ff;
   logic [bess_pkg::ID_W-1:0] rsp_id_ff;
   logic signed [SW-1:0]      rsp_sine_ff;

   // shared multiplier: squares of both vectors, then the dot terms
   always_comb begin
      case (step_ff)
         4'd0:    begin op_a = vx_ff; op_b = vx_ff; end
         4'd1:    begin op_a = vy_ff; op_b = vy_ff; end
         4'd2:    begin op_a = vz_ff; op_b = vz_ff; end
         4'd3:    begin op_a = gx_ff; op_b = gx_ff; end
         4'd4:    begin op_a = gy_ff; op_b = gy_ff; end
         4'd5:    begin op_a = gz_ff; op_b = gz_ff; end
         4'd6:    begin op_a = vx_ff; op_b = gx_ff; end
         4'd7:    begin op_a = vy_ff; op_b = gy_ff; end
         default: begin op_a = vz_ff; op_b = gz_ff; end
      endcase
      prod      = PW'(op_a) * PW'(op_b);
      prev_step = step_ff - 4'd1;
   end

   assign step_v = root_step(x_v_ff, r_v_ff, bit_ff);
   assign step_u = root_step(x_u_ff, r_u_ff, bit_ff);
   assign rem2   = {rem_ff[PW-2:0], 1'b0};

   always_comb begin
      if (zero_den_ff)      sine = bess_pkg::SINE_POS_MAX;
      else if (neg_ff)      sine = -$signed(q_ff);
      else if (q_ff[SW-1])  sine = bess_pkg::SINE_POS_MAX;
      else                  sine = $signed(q_ff);
      // a straight-down sine can never beat the initial bar of minus one
      qualify = (sine >= cfg.min_sine_elev) &&
                (have_ff ? (sine > best_sine_ff) : (sine != bess_pkg::SINE_NEG_MAX));
      have_in      = have_ff | qualify;
      best_sine_in = qualify ? sine  : best_sine_ff;
      best_id_in   = qualify ? id_ff : best_id_ff;
      out_free     = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in   = state_ff;
      item_ready = 1'b0;
      commit     = 1'b0;
      emit       = 1'b0;
      unique case (state_ff)
         bess_pkg::ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) state_in = bess_pkg::ST_MUL;
         end
         bess_pkg::ST_MUL: begin
            if (step_ff == 4'(bess_pkg::MUL_STEPS - 1)) state_in = bess_pkg::ST_SQRT;
         end
         bess_pkg::ST_SQRT: begin
            if (iter_ff == 5'(bess_pkg::SQRT_STEPS - 1)) state_in = bess_pkg::ST_DEN;
         end
         bess_pkg::ST_DEN: state_in = bess_pkg::ST_CHK;
         bess_pkg::ST_CHK: begin
            if (den_ff == '0 || mag_ff >= den_ff) state_in = bess_pkg::ST_SEL;
            else                                  state_in = bess_pkg::ST_DIV;
         end
         bess_pkg::ST_DIV: begin
            if (iter_ff == 5'(bess_pkg::SINE_FRAC - 1)) state_in = bess_pkg::ST_SEL;
         end
         bess_pkg::ST_SEL: begin
            if (!last_ff) begin
               commit   = 1'b1;
               state_in = bess_pkg::ST_IDLE;
            end else if (out_free) begin
               emit     = 1'b1;
               state_in = bess_pkg::ST_IDLE;
            end
         end
         default: state_in = bess_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bess_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         bess_pkg::ST_IDLE: begin
            vx_ff    <= DW'(item.sat_x) - DW'(cfg.station_x);
            vy_ff    <= DW'(item.sat_y) - DW'(cfg.station_y);
            vz_ff    <= DW'(item.sat_z) - DW'(cfg.station_z);
            gx_ff    <= DW'(cfg.station_x);
            gy_ff    <= DW'(cfg.station_y);
            gz_ff    <= DW'(cfg.station_z);
            id_ff    <= item.sat_id;
            last_ff  <= item.last_sat;
            step_ff  <= '0;
            acc_v_ff <= '0;
            acc_u_ff <= '0;
            dot_ff   <= '0;
         end
         bess_pkg::ST_MUL: begin
            prod_ff <= prod;
            step_ff <= step_ff + 4'd1;
            if (step_ff != '0) begin
               if (prev_step < 4'd3)      acc_v_ff <= acc_v_ff + prod_ff;
               else if (prev_step < 4'd6) acc_u_ff <= acc_u_ff + prod_ff;
               else                       dot_ff   <= dot_ff + prod_ff;
            end
            x_v_ff  <= RW'(acc_v_ff);
            x_u_ff  <= RW'(acc_u_ff);
            r_v_ff  <= '0;
            r_u_ff  <= '0;
            bit_ff  <= RW'(1) << (PW - 2);
            iter_ff <= '0;
         end
         bess_pkg::ST_SQRT: begin
            x_v_ff  <= step_v.x;
            r_v_ff  <= step_v.r;
            x_u_ff  <= step_u.x;
            r_u_ff  <= step_u.r;
            bit_ff  <= bit_ff >> 2;
            iter_ff <= iter_ff + 5'd1;
         end
         bess_pkg::ST_DEN: begin
            den_ff <= NW'(r_v_ff[DW-1:0]) * NW'(r_u_ff[DW-2:0]);
            mag_ff <= dot_ff[PW-1] ? NW'(-dot_ff) : NW'(dot_ff);
            neg_ff <= dot_ff[PW-1];
         end
         bess_pkg::ST_CHK: begin
            zero_den_ff <= (den_ff == '0);
            q_ff        <= (mag_ff >= den_ff) ? SW'(1) << (SW - 1) : '0;
            rem_ff      <= PW'(mag_ff);
            iter_ff     <= '0;
         end
         bess_pkg::ST_DIV: begin
            if (rem2 >= PW'(den_ff)) begin
               rem_ff <= rem2 - PW'(den_ff);
               q_ff   <= {q_ff[SW-2:0], 1'b1};
            end else begin
               rem_ff <= rem2;
               q_ff   <= {q_ff[SW-2:0], 1'b0};
            end
            iter_ff <= iter_ff + 5'd1;
         end
         default: ;
      endcase
      if (commit) begin
         best_sine_ff <= best_sine_in;
         best_id_ff   <= best_id_in;
      end
      if (emit) begin
         rsp_found_ff <= have_in;
         rsp_id_ff    <= have_in ? best_id_in : '0;
         rsp_sine_ff  <= have_in ? best_sine_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit)    have_ff <= have_in;
         else if (emit) have_ff <= 1'b0;
         if (emit)            rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_best_id   = rsp_id_ff;
   assign rsp_best_sine = rsp_sine_ff;

endmodule

FILE: hdl/best_elevation_satellite_select_core.sv
// Highest-elevation satellite selector for one ground station.
// req channel: one satellite per beat. tdata holds sat_x, sat_y, sat_z (27 bits
// signed each) and sat_id (10 bits); tlast marks the final satellite of a pass.
// rsp channel: one beat per pass, after the tlast satellite has been evaluated.
// tdata holds best_id and best_sine (Q1.15); tuser is found. Both are zero when
// no satellite reached the threshold.
// csr channel: index 0..2 station x/y/z, 3 minimum sine; other indexes ignored.
// Write it only while no pass is in flight. csr_ready is always high.
// Each satellite passes through the back end in order: it is taken from the queue,
// then come the shared multiplier, the square-root loop, the denominator
// product, a check, the divider steps and a select. The divider is skipped when
// the sine saturates or a length is zero. The back end takes a new satellite
// from the queue only after it has finished the previous one.
// A two-entry queue in front lets new beats in while the back end works, and
// the rsp output register lets the next satellite start while a result waits.
// A result held by rsp_tready low stalls only the next tlast satellite.
// Reset restores the default station and threshold and clears the pass state.
module best_elevation_satellite_select_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sat_x[26:0], sat_y[53:27], sat_z[80:54], sat_id[90:81], zero[95:91]
   input  logic [bess_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // best_id[9:0], best_sine[25:10], zero[31:26]
   output logic [bess_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // found[0]
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bess_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bess_pkg::POS_W-1:0]          csr_data
);

   bess_pkg::cfg_type                   cfg;
   bess_pkg::sat_item_type              item;
   logic                                item_valid, item_ready;
   logic [bess_pkg::ID_W-1:0]           best_id;
   logic signed [bess_pkg::SINE_W-1:0]  best_sine;

   bess_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bess_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   bess_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_found     (rsp_tuser),
      .rsp_best_id   (best_id),
      .rsp_best_sine (best_sine)
   );

   assign rsp_tdata = {{(bess_pkg::RSP_DATA_W - bess_pkg::ID_W - bess_pkg::SINE_W){1'b0}},
                       best_sine, best_id};

endmodule

FILE: hdl/bess_checker.sv
module bess_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bess_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // nothing pending comes out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("empty pass reports nonzero id or sine");

   // straight down never qualifies
   a_found_not_down: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[25:10] != bess_pkg::SINE_NEG_MAX)
      else $error("found with sine of minus one");

endmodule

bind best_elevation_satellite_select_core bess_checker u_bess_checker (.*);

FILE: bench/best_elevation_satellite_select_core_tb.sv
`timescale 1ns / 100ps

module best_elevation_satellite_select_core_tb;

   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  DRAIN_WAIT  = 80;
   localparam int  PHASE_ITEMS = 220;
   localparam logic [bess_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd5;
   localparam longint POS_MAX = 67108863;
   localparam longint POS_MIN = -67108864;

   typedef struct {
      bit          found;
      bit [9:0]    best_id;
      bit [15:0]   best_sine;
   } pass_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bess_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bess_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [bess_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [bess_pkg::POS_W-1:0]       csr_data = '0;

   best_elevation_satellite_select_core uut (.*);

   // station and threshold as the block should hold them
   longint       gs_x = 6371000, gs_y = 0, gs_z = 0, min_sine = 5690;
   // running pass state
   bit           pass_found;
   longint       pass_sine;
   bit [9:0]     pass_id;

   bess_pkg::sat_item_type sats_pending[$];
   bess_pkg::sat_item_type sat_cur;
   pass_result_type        results_due[$];
   int           send_gap, rsp_stall;
   bit           calm;
   int           errors, n_sats, n_results, n_found, n_cycles;

   initial forever #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root = 0, bitv = 64'h4000_0000_0000_0000;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Q1.15 sine of elevation, saturated; zero length counts as plus one
   function automatic longint elevation_sine(longint sx, longint sy, longint sz);
      longint vx = sx - gs_x, vy = sy - gs_y, vz = sz - gs_z;
      longint dot = vx * gs_x + vy * gs_y + vz * gs_z;
      longint unsigned nv = int_sqrt(vx * vx + vy * vy + vz * vz);
      longint unsigned nu = int_sqrt(gs_x * gs_x + gs_y * gs_y + gs_z * gs_z);
      longint unsigned den = nv * nu;
      longint unsigned mag, q, rem;
      if (den == 0) return 32767;
      mag = (dot < 0) ? -dot : dot;
      q = mag / den;
      rem = mag % den;
      if (q >= 1) begin
         q = 32768;
      end else begin
         for (int i = 0; i < bess_pkg::SINE_FRAC; i++) begin
            rem <<= 1;
            q <<= 1;
            if (rem >= den) begin
               rem -= den;
               q |= 1;
            end
         end
      end
      if (dot < 0) return -longint'(q);
      return (q > 32767) ? 32767 : longint'(q);
   endfunction

   function automatic void track_sat(bess_pkg::sat_item_type s);
      longint sine = elevation_sine(s.sat_x, s.sat_y, s.sat_z);
      longint bar = pass_found ? pass_sine : -32768;
      pass_result_type r;
      n_sats++;
      if (sine >= min_sine && sine > bar) begin
         pass_found = 1'b1;
         pass_sine = sine;
         pass_id = s.sat_id;
      end
      if (s.last_sat) begin
         r.found = pass_found;
         r.best_id = pass_found ? pass_id : '0;
         r.best_sine = pass_found ? pass_sine[15:0] : '0;
         results_due.insert(results_due.size(), r);
         pass_found = 1'b0;
         pass_sine = 0;
         pass_id = '0;
      end
   endfunction

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   // driver
   always @(posedge clock) begin
      bit holding;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         holding = req_tvalid;
         if (req_tvalid && req_tready) begin
            track_sat(sat_cur);
            holding = 1'b0;
            send_gap = draw_wait();
         end
         if (!holding) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (sats_pending.size() > 0) begin
               sat_cur = sats_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {5'b0, sat_cur.sat_id, sat_cur.sat_z, sat_cur.sat_y,
                             sat_cur.sat_x};
               req_tlast <= sat_cur.last_sat;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pass_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (results_due.size() == 0) begin
               errors++;
               $display("%0t: result beat with none expected, actual found=%0b id=%0d sine=%0d",
                        $time, rsp_tuser, rsp_tdata[9:0], $signed(rsp_tdata[25:10]));
            end else begin
               want = results_due.pop_front();
               if (want.found) n_found++;
               if (rsp_tuser !== want.found || rsp_tdata[9:0] !== want.best_id ||
                   rsp_tdata[25:10] !== want.best_sine || rsp_tdata[31:26] !== 6'b0) begin
                  errors++;
                  $display("%0t: mismatch expected found=%0b id=%0d sine=%0d, actual found=%0b id=%0d sine=%0d tdata=%h",
                           $time, want.found, want.best_id, $signed(want.best_sine),
                           rsp_tuser, rsp_tdata[9:0], $signed(rsp_tdata[25:10]), rsp_tdata);
               end
            end
            rsp_stall = draw_wait();
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_tready <= (rsp_stall == 0);
      end
   end

   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", n_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [bess_pkg::CSR_IDX_W-1:0] idx, longint value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[bess_pkg::POS_W-1:0];
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      case (idx)
         bess_pkg::REG_STATION_X: gs_x = $signed(value[bess_pkg::POS_W-1:0]);
         bess_pkg::REG_STATION_Y: gs_y = $signed(value[bess_pkg::POS_W-1:0]);
         bess_pkg::REG_STATION_Z: gs_z = $signed(value[bess_pkg::POS_W-1:0]);
         bess_pkg::REG_MIN_SINE:  min_sine = $signed(value[bess_pkg::SINE_W-1:0]);
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_station(longint x, longint y, longint z, longint thr);
      csr_write(bess_pkg::REG_STATION_X, x);
      csr_write(bess_pkg::REG_STATION_Y, y);
      csr_write(bess_pkg::REG_STATION_Z, z);
      csr_write(bess_pkg::REG_MIN_SINE, thr);
   endtask

   function automatic longint clip(longint v);
      return (v > POS_MAX) ? POS_MAX : (v < POS_MIN) ? POS_MIN : v;
   endfunction

   function automatic logic [bess_pkg::POS_W-1:0] to_pos(longint v);
      longint c = clip(v);
      return c[bess_pkg::POS_W-1:0];
   endfunction

   function automatic void add_sat(longint x, longint y, longint z, int id, bit last);
      bess_pkg::sat_item_type s;
      s.sat_x = to_pos(x);
      s.sat_y = to_pos(y);
      s.sat_z = to_pos(z);
      s.sat_id = id[bess_pkg::ID_W-1:0];
      s.last_sat = last;
      sats_pending.insert(sats_pending.size(), s);
   endfunction

   function automatic longint spread(int r);
      return longint'($urandom_range(0, 2 * r)) - r;
   endfunction

   function automatic longint any_pos();
      return $signed(27'($urandom()));
   endfunction

   // passes of random length; mostly sats around the station, some odd cases
   function automatic void add_passes(int count);
      int left = 0;
      longint px = 0, py = 0, pz = 0;
      for (int i = 0; i < count; i++) begin
         if (left == 0) left = $urandom_range(1, 8);
         left--;
         case ($urandom_range(0, 9))
            6: begin px = any_pos(); py = any_pos(); pz = any_pos(); end
            7: begin px = gs_x; py = gs_y; pz = gs_z; end
            8: begin px = gs_x / 2; py = gs_y / 2; pz = gs_z / 2; end
            9: ;  // repeat previous position: tie
            default: begin
               px = gs_x + gs_x / 10 + spread(3000000);
               py = gs_y + gs_y / 10 + spread(3000000);
               pz = gs_z + gs_z / 10 + spread(3000000);
            end
         endcase
         add_sat(px, py, pz, $urandom_range(0, 1023), left == 0 || i == count - 1);
      end
   endfunction

   task automatic run_and_drain();
      while (sats_pending.size() > 0 || req_tvalid || results_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset: station on the x axis, threshold about ten degrees
      calm = 1'b1;
      add_sat(6371000, 0, 0, 1023, 1'b0);              // at the station
      add_sat(7000000, 0, 0, 0, 1'b1);                 // straight up, tie at +1
      add_sat(3000000, 0, 0, 5, 1'b1);                 // straight down only
      add_sat(POS_MAX, POS_MAX, POS_MAX, 17, 1'b0);
      add_sat(POS_MIN, POS_MIN, POS_MIN, 18, 1'b0);
      add_sat(6800000, 900000, 0, 40, 1'b0);
      add_sat(6800000, 900000, 0, 41, 1'b0);           // equal sine, keep 40
      add_sat(6500000, 3000000, -2000000, 42, 1'b1);
      add_sat(6371000, 7000000, 0, 600, 1'b1);         // near horizon, below threshold
      add_sat(POS_MAX, 0, POS_MIN, 1023, 1'b1);
      run_and_drain();

      calm = 1'b0;
      csr_write(REG_UNUSED, 12345);                    // ignored
      set_station(0, 4000000, 5000000, 0);
      add_passes(PHASE_ITEMS);
      run_and_drain();

      set_station(POS_MIN, POS_MAX, POS_MIN, -32768);
      add_sat(POS_MIN / 2, POS_MAX / 2, POS_MIN / 2, 7, 1'b1);  // straight down never wins
      add_passes(PHASE_ITEMS);
      run_and_drain();

      calm = 1'b1;
      set_station(0, 0, 0, 32767);                     // station at origin: all +1
      add_passes(60);
      run_and_drain();

      calm = 1'b0;
      set_station(POS_MAX, POS_MIN, POS_MAX, 32767);
      add_passes(120);
      run_and_drain();

      repeat (2) begin
         set_station(spread(6400000), spread(6400000), spread(6400000),
                     longint'($urandom_range(0, 65535)) - 32768);
         add_passes(PHASE_ITEMS);
         run_and_drain();
      end
      set_station(-3000000, 4000000, 4200000, 5690);
      add_passes(PHASE_ITEMS);
      run_and_drain();

      $display("covered %0d satellites in %0d passes, %0d with a qualifying satellite",
               n_sats, n_results, n_found);
      $display("station settings included origin and range extremes, thresholds -1 to +1");
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/bess_pkg.sv
hdl/bess_csr.sv
hdl/bess_front.sv
hdl/bess_back.sv
hdl/best_elevation_satellite_select_core.sv
hdl/bess_checker.sv
bench/best_elevation_satellite_select_core_tb.sv
